// File: rtl/dbct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dbct_pkg;

  localparam int DEPTH_W = 14;
  localparam int CNT_W   = 18;
  localparam int SUM_W   = 27;
  localparam int GRAY_W  = 8;
  localparam int POS_W   = 9;
  localparam int CFG_W   = 18;
  localparam int IDX_W   = 2;
  localparam int ITER_W  = 5;

  localparam logic [IDX_W-1:0] CFG_MIN_DEPTH  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_MAX_DEPTH  = 2'd1;
  localparam logic [IDX_W-1:0] CFG_MIN_PIXELS = 2'd2;

  localparam logic [DEPTH_W-1:0] MIN_DEPTH_RST  = 14'd10;
  localparam logic [DEPTH_W-1:0] MAX_DEPTH_RST  = 14'd1100;
  localparam logic [CNT_W-1:0]   MIN_PIXELS_RST = 18'd20;

  typedef enum logic {
    ST_STREAM,
    ST_DIVIDE
  } state_t;

  typedef struct packed {
    logic accept;
    logic start_div;
    logic div_step;
    logic load_out;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
  } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/dbct_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dbct_ctrl
  import dbct_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  wire        out_stall,
  input  dp_status_t status,
  output ctl_cmd_t   cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_STREAM;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_STREAM: begin
        in_stall   = !out_free;
        cmd.accept = in_valid && out_free;
        if (cmd.accept) begin
          if (status.need_div) begin
            cmd.start_div = 1'b1;
            state_nxt     = ST_DIVIDE;
          end else begin
            cmd.load_out = 1'b1;
          end
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_STREAM;
        end
      end
      default: state_nxt = ST_STREAM;
    endcase
    // The output register is always empty when a division completes.
    out_valid_nxt = cmd.load_out || cmd.finish || (out_valid_r && out_stall);
  end

endmodule

`default_nettype wire

// File: rtl/dbct_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module dbct_datapath
  import dbct_pkg::*;
#(
  parameter int FRAME_WIDTH  = 512,
  parameter int FRAME_HEIGHT = 424
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire  [IDX_W-1:0]   cfg_index,
  input  wire  [CFG_W-1:0]   cfg_data,
  input  wire  [DEPTH_W-1:0] in_depth,
  input  wire                in_last_pixel,
  input  ctl_cmd_t           cmd,
  output dp_status_t         status,
  output logic [GRAY_W-1:0]  out_gray_level,
  output logic [POS_W-1:0]   out_hand_x,
  output logic [POS_W-1:0]   out_hand_y,
  output logic               out_position_updated
);

  localparam int COL_W = (FRAME_WIDTH > 2) ? $clog2(FRAME_WIDTH) : 1;
  localparam int ROW_W = (FRAME_HEIGHT > 2) ? $clog2(FRAME_HEIGHT) : 1;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(FRAME_WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(FRAME_HEIGHT - 1);
  localparam logic [SUM_W-1:0] SUM_TOP  = '1;
  localparam logic [CNT_W-1:0] CNT_TOP  = '1;

  logic [DEPTH_W-1:0] min_depth_r, max_depth_r;
  logic [CNT_W-1:0]   min_pixels_r;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [SUM_W-1:0] sum_col_r, sum_col_nxt, sum_row_r, sum_row_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [POS_W-1:0] held_x_r, held_y_r;

  logic [GRAY_W-1:0] gray_hold_r, gray_out_r;
  logic              updated_r;

  // Divider state: dividends shift out MSB first, remainders build up.
  logic [SUM_W-1:0]  num_x_r, num_y_r;
  logic [CNT_W-1:0]  rem_x_r, rem_y_r, den_r;
  logic [POS_W-1:0]  q_x_r, q_y_r;
  logic [ITER_W-1:0] iter_r;

  logic                in_band;
  logic [SUM_W:0]      add_col, add_row;
  logic [DEPTH_W+7:0]  prod;
  logic [GRAY_W-1:0]   gray;
  logic [CNT_W:0]      trial_x, trial_y;
  logic                qbit_x, qbit_y;
  logic [CNT_W-1:0]    rem_x_nxt, rem_y_nxt;

  assign in_band = (in_depth >= min_depth_r) && (in_depth <= max_depth_r);
  assign prod    = {in_depth, 8'd0} - {8'd0, in_depth};
  assign gray    = in_band ? (8'd255 - prod[DEPTH_W+7:DEPTH_W]) : '0;

  assign add_col = {1'b0, sum_col_r} + (SUM_W+1)'(col_r);
  assign add_row = {1'b0, sum_row_r} + (SUM_W+1)'(row_r);

  always_comb begin
    sum_col_nxt = sum_col_r;
    sum_row_nxt = sum_row_r;
    cnt_nxt     = cnt_r;
    if (in_band) begin
      sum_col_nxt = add_col[SUM_W] ? SUM_TOP : add_col[SUM_W-1:0];
      sum_row_nxt = add_row[SUM_W] ? SUM_TOP : add_row[SUM_W-1:0];
      cnt_nxt     = (cnt_r == CNT_TOP) ? CNT_TOP : cnt_r + 1'b1;
    end
    col_nxt = col_r + 1'b1;
    row_nxt = row_r;
    if (col_r == COL_LAST) begin
      col_nxt = '0;
      row_nxt = (row_r == ROW_LAST) ? '0 : row_r + 1'b1;
    end
  end

  assign status.need_div = in_last_pixel && (cnt_nxt > min_pixels_r);
  assign status.div_last = (iter_r == '0);

  assign trial_x   = {rem_x_r, num_x_r[SUM_W-1]};
  assign trial_y   = {rem_y_r, num_y_r[SUM_W-1]};
  assign qbit_x    = trial_x >= {1'b0, den_r};
  assign qbit_y    = trial_y >= {1'b0, den_r};
  assign rem_x_nxt = qbit_x ? CNT_W'(trial_x - {1'b0, den_r}) : trial_x[CNT_W-1:0];
  assign rem_y_nxt = qbit_y ? CNT_W'(trial_y - {1'b0, den_r}) : trial_y[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_depth_r  <= MIN_DEPTH_RST;
      max_depth_r  <= MAX_DEPTH_RST;
      min_pixels_r <= MIN_PIXELS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_DEPTH:  min_depth_r  <= cfg_data[DEPTH_W-1:0];
        CFG_MAX_DEPTH:  max_depth_r  <= cfg_data[DEPTH_W-1:0];
        CFG_MIN_PIXELS: min_pixels_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      sum_col_r <= '0;
      sum_row_r <= '0;
      cnt_r     <= '0;
      held_x_r  <= '0;
      held_y_r  <= '0;
    end else begin
      if (cmd.accept) begin
        if (in_last_pixel) begin
          col_r     <= '0;
          row_r     <= '0;
          sum_col_r <= '0;
          sum_row_r <= '0;
          cnt_r     <= '0;
        end else begin
          col_r     <= col_nxt;
          row_r     <= row_nxt;
          sum_col_r <= sum_col_nxt;
          sum_row_r <= sum_row_nxt;
          cnt_r     <= cnt_nxt;
        end
      end
      if (cmd.finish) begin
        held_x_r <= {q_x_r[POS_W-2:0], qbit_x};
        held_y_r <= {q_y_r[POS_W-2:0], qbit_y};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      gray_hold_r <= gray;
    end
    if (cmd.start_div) begin
      num_x_r <= sum_col_nxt;
      num_y_r <= sum_row_nxt;
      den_r   <= cnt_nxt;
      rem_x_r <= '0;
      rem_y_r <= '0;
      q_x_r   <= '0;
      q_y_r   <= '0;
      iter_r  <= ITER_W'(SUM_W - 1);
    end else if (cmd.div_step) begin
      num_x_r <= {num_x_r[SUM_W-2:0], 1'b0};
      num_y_r <= {num_y_r[SUM_W-2:0], 1'b0};
      rem_x_r <= rem_x_nxt;
      rem_y_r <= rem_y_nxt;
      q_x_r   <= {q_x_r[POS_W-2:0], qbit_x};
      q_y_r   <= {q_y_r[POS_W-2:0], qbit_y};
      iter_r  <= iter_r - 1'b1;
    end
    if (cmd.load_out) begin
      gray_out_r <= gray;
      updated_r  <= 1'b0;
    end else if (cmd.finish) begin
      gray_out_r <= gray_hold_r;
      updated_r  <= 1'b1;
    end
  end

  // The held position only changes when the output register is empty.
  assign out_gray_level       = gray_out_r;
  assign out_hand_x           = held_x_r;
  assign out_hand_y           = held_y_r;
  assign out_position_updated = updated_r;

endmodule

`default_nettype wire

// File: rtl/depth_band_centroid_tracker.sv
// An accepted pixel's result enters the output register in the next cycle; a
// frame's last pixel that updates the position instead goes through the
// 27-step restoring divider that forms both centroid coordinates at once.
// Throughput: one pixel per cycle unless out_stall holds it or the divider runs.
// Reset (rst_n, synchronous, active low) clears counters, sums, held position,
// output valid, and restores min_depth=10, max_depth=1100, min_pixels=20.
`timescale 1ns / 1ps
`default_nettype none

module depth_band_centroid_tracker
  import dbct_pkg::*;
#(
  parameter int FRAME_WIDTH  = 512,
  parameter int FRAME_HEIGHT = 424
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire  [IDX_W-1:0]   cfg_index,
  input  wire  [CFG_W-1:0]   cfg_data,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire  [DEPTH_W-1:0] in_depth,
  input  wire                in_last_pixel,
  output logic               out_valid,
  input  wire                out_stall,
  output logic [GRAY_W-1:0]  out_gray_level,
  output logic [POS_W-1:0]   out_hand_x,
  output logic [POS_W-1:0]   out_hand_y,
  output logic               out_position_updated
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  dbct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  dbct_datapath #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_depth             (in_depth),
    .in_last_pixel        (in_last_pixel),
    .cmd                  (cmd),
    .status               (status),
    .out_gray_level       (out_gray_level),
    .out_hand_x           (out_hand_x),
    .out_hand_y           (out_hand_y),
    .out_position_updated (out_position_updated)
  );

endmodule

`default_nettype wire
